// ----- design/lfr_pkg.sv -----
// ---------------------------------------------------------------------------
// lfr_pkg
// Shared types and codes for the streaming literal find/replace core.
// ---------------------------------------------------------------------------
package lfr_pkg;
    localparam int CHAR_W  = 21;
    localparam int COUNT_W = 16;

    localparam logic [1:0] OP_LOAD_SEARCH  = 2'd0;
    localparam logic [1:0] OP_LOAD_REPLACE = 2'd1;
    localparam logic [1:0] OP_STREAM       = 2'd2;
    localparam logic [1:0] OP_END          = 2'd3;

    localparam logic [1:0] REG_SEARCH_LEN  = 2'd0;
    localparam logic [1:0] REG_REPLACE_LEN = 2'd1;
    localparam logic [1:0] REG_MAX_REPL    = 2'd2;

    typedef logic [CHAR_W-1:0] t_char;

    // Shift and load control fed to every pending cell.
    typedef struct packed {
        logic  shift;    // move every cell down by one
        logic  load;     // write new char into the target cell
        t_char load_char;
    } t_cell_ctl;
endpackage

// ----- design/lfr_cell.sv -----
// ---------------------------------------------------------------------------
// lfr_cell
// One pending-buffer cell: holds a char, compares it to its search char.
// ---------------------------------------------------------------------------
module lfr_cell
    import lfr_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_target,   // this cell receives the load
    input  t_char     i_next_char, // neighbor above
    input  t_char     i_search_char,
    output t_char     o_char,
    output logic      o_eq
);
    t_char r_char;
    t_char n_char;

    always_comb begin
        n_char = r_char;
        if (i_ctl.load && i_target) begin
            n_char = i_ctl.load_char;
        end else if (i_ctl.shift) begin
            n_char = i_next_char;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;
    assign o_eq   = (r_char == i_search_char);
endmodule

// ----- design/literal_find_replace_stream_core.sv -----
// ---------------------------------------------------------------------------
// literal_find_replace_stream_core
// Streaming literal search and replace over code points.
// ---------------------------------------------------------------------------
// Pending chars sit in a row of MAX_SEARCH cells. Each cell compares its
// char with the search char at its position, and the row shifts down one
// place per output beat taken from the row. One item is taken at a time.
// A stream char that arrives while replacing is off enters the row, and the
// row is then flushed one beat at a time. An end item flushes the row, or
// emits the replacement or an end marker. A stream char that arrives while
// replacing is on enters the row, is compared in the check state, and only
// then are any beats emitted. A char that only joins the pending row passes
// through the check state and emits nothing. Each beat waits in the output
// register while the receiver stalls.
// ---------------------------------------------------------------------------
module literal_find_replace_stream_core
    import lfr_pkg::*;
#(
    parameter int MAX_SEARCH  = 16,
    parameter int MAX_REPLACE = 32
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [1:0]   i_opcode,
    input  logic [4:0]   i_slot,
    input  logic [20:0]  i_code_point,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [20:0]  o_out_char,
    output logic         o_char_valid,
    output logic         o_run_last,
    output logic [15:0]  o_matches_so_far,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    localparam int SW = $clog2(MAX_SEARCH + 1);
    localparam int RW = $clog2(MAX_REPLACE + 1);
    localparam int SI = (MAX_SEARCH > 1) ? $clog2(MAX_SEARCH) : 1;
    localparam int RI = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;  // stream char placed, decide
    localparam logic [2:0] ST_DRAIN = 3'd2;  // emit head until prefix again
    localparam logic [2:0] ST_REPL  = 3'd3;  // emit replacement
    localparam logic [2:0] ST_FLUSH = 3'd4;  // emit all pending
    localparam logic [2:0] ST_MARK  = 3'd5;  // end marker

    logic [4:0]    r_search_len;
    logic [5:0]    r_replace_len;
    logic [15:0]   r_max;
    logic [2:0]    r_state;
    logic [SW-1:0] r_pcount;
    logic [15:0]   r_total;
    logic          r_seen;
    logic          r_is_end;    // current item is an end of string
    logic [RW-1:0] r_ridx;

    t_char r_search [MAX_SEARCH];
    t_char r_replace [MAX_REPLACE];

    // output register
    logic        r_ov;
    t_char       r_oc;
    logic        r_ocv, r_ol;
    logic [15:0] r_ocnt;

    // effective lengths
    logic [SW-1:0] len;
    logic [RW-1:0] rlen;
    assign len  = (32'(r_search_len) > MAX_SEARCH) ? SW'(MAX_SEARCH) :
                  SW'(r_search_len);
    assign rlen = (32'(r_replace_len) > MAX_REPLACE) ? RW'(MAX_REPLACE) :
                  RW'(r_replace_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_len  <= '0;
            r_replace_len <= '0;
            r_max         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SEARCH_LEN:  r_search_len  <= i_cfg_data[4:0];
                REG_REPLACE_LEN: r_replace_len <= i_cfg_data[5:0];
                REG_MAX_REPL:    r_max         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- cells
    t_cell_ctl cell_ctl;
    t_char     cell_char [MAX_SEARCH];
    logic      cell_eq   [MAX_SEARCH];
    logic [SI-1:0] tgt_idx;

    genvar g;
    generate
        for (g = 0; g < MAX_SEARCH; g++) begin : g_cell
            t_char up;
            if (g == MAX_SEARCH - 1) begin : g_top
                assign up = cell_char[g];
            end else begin : g_mid
                assign up = cell_char[g+1];
            end
            lfr_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_target     (tgt_idx == SI'(g)),
                .i_next_char  (up),
                .i_search_char(r_search[g]),
                .o_char       (cell_char[g]),
                .o_eq         (cell_eq[g])
            );
        end
    endgenerate

    // prefix check over pending count
    logic is_prefix;
    always_comb begin
        is_prefix = 1'b1;
        for (int k = 0; k < MAX_SEARCH; k++) begin
            if (SW'(k) < r_pcount && !cell_eq[k]) is_prefix = 1'b0;
        end
    end

    // same check on the row as it stands after one shift
    logic is_prefix_sh;
    always_comb begin
        is_prefix_sh = 1'b1;
        for (int k = 0; k < MAX_SEARCH - 1; k++) begin
            if (SW'(k + 1) < r_pcount && cell_char[k+1] != r_search[k])
                is_prefix_sh = 1'b0;
        end
    end

    logic in_acc, out_free;
    logic enabled;
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_free;
    assign enabled  = (len != '0) && ((r_max == '0) || (r_total < r_max));

    logic [2:0]    n_state;
    logic [SW-1:0] n_pcount;
    logic [15:0]   n_total;
    logic          n_seen, n_is_end;
    logic [RW-1:0] n_ridx;
    logic          emit;
    t_char         emit_char;
    logic          emit_cv, emit_last;

    always_comb begin
        n_state   = r_state;
        n_pcount  = r_pcount;
        n_total   = r_total;
        n_seen    = r_seen;
        n_is_end  = r_is_end;
        n_ridx    = r_ridx;
        cell_ctl  = '0;
        tgt_idx   = r_pcount[SI-1:0];
        emit      = 1'b0;
        emit_char = '0;
        emit_cv   = 1'b1;
        emit_last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_opcode)
                        OP_STREAM: begin
                            n_seen = 1'b1;
                            n_is_end = 1'b0;
                            cell_ctl.load_char = i_code_point;
                            cell_ctl.load = 1'b1;
                            if (32'(r_pcount) >= MAX_SEARCH) begin
                                tgt_idx  = SI'(MAX_SEARCH - 1);
                                n_pcount = SW'(MAX_SEARCH);
                            end else begin
                                n_pcount = r_pcount + SW'(1);
                            end
                            n_state = enabled ? ST_CHECK : ST_FLUSH;
                        end
                        OP_END: begin
                            n_is_end = 1'b1;
                            n_ridx = '0;
                            if (!r_seen && len == '0) begin
                                n_total = 16'd1;
                                n_state = (rlen == '0) ? ST_MARK : ST_REPL;
                            end else begin
                                n_state = (r_pcount == '0) ? ST_MARK : ST_FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                if (r_pcount == len && is_prefix) begin
                    n_pcount = '0;
                    n_total  = (r_total != 16'hFFFF) ? r_total + 16'd1 : r_total;
                    n_ridx   = '0;
                    n_state  = (rlen == '0) ? ST_IDLE : ST_REPL;
                end else if (r_pcount < len && is_prefix) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_char = cell_char[0];
                    cell_ctl.shift = 1'b1;
                    n_pcount = r_pcount - SW'(1);
                    // last when the shifted row is empty or a proper prefix
                    emit_last = (r_pcount == SW'(1)) ||
                                ((r_pcount - SW'(1)) < len && is_prefix_sh);
                    if (emit_last) n_state = ST_IDLE;
                end
            end
            ST_REPL: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_char = r_replace[r_ridx[RI-1:0]];
                    n_ridx = r_ridx + RW'(1);
                    if (r_ridx + RW'(1) == rlen) begin
                        emit_last = 1'b1;
                        n_state = ST_IDLE;
                        if (r_is_end) begin
                            n_total = '0;
                            n_seen = 1'b0;
                            n_pcount = '0;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_char = cell_char[0];
                    cell_ctl.shift = 1'b1;
                    n_pcount = r_pcount - SW'(1);
                    if (r_pcount == SW'(1)) begin
                        emit_last = 1'b1;
                        n_state = ST_IDLE;
                        if (r_is_end) begin
                            n_total = '0;
                            n_seen = 1'b0;
                        end
                    end
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_cv = 1'b0;
                    emit_last = 1'b1;
                    n_state = ST_IDLE;
                    n_total = '0;
                    n_seen = 1'b0;
                    n_pcount = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pcount <= '0;
            r_total  <= '0;
            r_seen   <= 1'b0;
            r_is_end <= 1'b0;
            r_ridx   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pcount <= n_pcount;
            r_total  <= n_total;
            r_seen   <= n_seen;
            r_is_end <= n_is_end;
            r_ridx   <= n_ridx;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // count shown with each beat is the total after the item
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oc   <= emit_char;
            r_ocv  <= emit_cv;
            r_ol   <= emit_last;
            r_ocnt <= r_total;
        end
    end

    assign o_valid          = r_ov;
    assign o_out_char       = r_oc;
    assign o_char_valid     = r_ocv;
    assign o_run_last       = r_ol;
    assign o_matches_so_far = r_ocnt;

    // stores
    always_ff @(posedge i_clk) begin
        if (in_acc && i_opcode == OP_LOAD_SEARCH && 32'(i_slot) < MAX_SEARCH)
            r_search[SI'(i_slot)] <= i_code_point;
        if (in_acc && i_opcode == OP_LOAD_REPLACE && 32'(i_slot) < MAX_REPLACE)
            r_replace[RI'(i_slot)] <= i_code_point;
    end
endmodule

// ----- design/lfr_checker.sv -----
// ---------------------------------------------------------------------------
// lfr_checker
// Port-level checks for the literal find/replace core.
// ---------------------------------------------------------------------------
module lfr_checker
    import lfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_ready,
    input logic        o_char_valid,
    input logic        o_run_last,
    input logic [20:0] o_out_char
);
    // end marker always carries a zero char and closes the item
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_run_last && o_out_char == '0)
        else $error("end marker malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char))
        else $error("stalled beat changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind literal_find_replace_stream_core lfr_checker u_lfr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_ready(o_ready), .o_char_valid(o_char_valid), .o_run_last(o_run_last),
    .o_out_char(o_out_char)
);
